@@ sv/rate_spec_parser_assert.svh @@
// Assertion macros for the rate text parser.
`ifndef RATE_SPEC_PARSER_ASSERT_SVH
`define RATE_SPEC_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define RSP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rate_spec_parser: assertion failed");
// Next-cycle implication, disabled while reset is held.
`define RSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rate_spec_parser: assertion failed");
`else
`define RSP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RSP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ sv/rsp_pkg.sv @@
// Shared types and constants of the rate text parser.
`timescale 1ns / 1ps
package rsp_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned WORD_W = 32;

    // Parse phase codes
    localparam logic [1:0] PH_RATE  = 2'd0;
    localparam logic [1:0] PH_SLASH = 2'd1;
    localparam logic [1:0] PH_WIN   = 2'd2;
    localparam logic [1:0] PH_ERR   = 2'd3;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_H     = 8'h68;

    // Unit factors to milliseconds and the largest window each allows
    localparam logic [31:0] U32_TOP   = 32'hFFFF_FFFF;
    localparam logic [21:0] FACTOR_S  = 22'd1000;
    localparam logic [21:0] FACTOR_M  = 22'd60000;
    localparam logic [21:0] FACTOR_H  = 22'd3600000;
    localparam logic [31:0] LIMIT_S   = 32'(U32_TOP / 32'd1000);
    localparam logic [31:0] LIMIT_M   = 32'(U32_TOP / 32'd60000);
    localparam logic [31:0] LIMIT_H   = 32'(U32_TOP / 32'd3600000);

    typedef struct packed {
        logic             is_last;
        logic [CHAR_W-1:0] char_byte;
    } rsp_item_t;

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] window_ms;
        logic [WORD_W-1:0] rate_count;
    } rsp_result_t;

endpackage

@@ sv/rsp_in_stage.sv @@
// Input register stage of the rate text parser.
`timescale 1ns / 1ps
module rsp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] char_byte
    input  logic              s_tlast,   // is_last
    input  logic              advance,
    output logic              item_valid,
    output rsp_pkg::rsp_item_t item
);
    import rsp_pkg::*;

    logic      valid_reg, valid_next;
    rsp_item_t item_reg, item_next;
    logic      load;

    // Take a request when the stage is empty or drains this cycle
    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load) begin
            valid_next        = 1'b1;
            item_next.char_byte = s_tdata;
            item_next.is_last   = s_tlast;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ sv/rsp_parse_core.sv @@
// Parse state and per-byte step logic of the rate text parser.
`timescale 1ns / 1ps
module rsp_parse_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  rsp_pkg::rsp_item_t   item,
    output rsp_pkg::rsp_result_t result
);
    import rsp_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic [31:0] rate_acc_reg, rate_acc_next;
    logic [31:0] window_acc_reg, window_acc_next;

    logic        is_digit;
    logic [31:0] acc_src;
    logic [35:0] acc_sum;
    logic        acc_ovf;
    logic [21:0] factor;
    logic [31:0] limit;
    logic        unit_ok;
    logic [31:0] win;
    logic [53:0] ms_prod;
    logic        ok;

    assign is_digit = (item.char_byte >= CH_ZERO) && (item.char_byte <= CH_NINE);

    // Shared multiply-by-ten and add: acc*8 + acc*2 + digit
    assign acc_src = (phase_reg == PH_RATE) ? rate_acc_reg : window_acc_reg;
    assign acc_sum = ({4'd0, acc_src} << 3) + ({4'd0, acc_src} << 1)
                   + {32'd0, item.char_byte[3:0]};
    assign acc_ovf = |acc_sum[35:32];

    // Decode the unit on the final byte
    always_comb begin
        factor  = '0;
        limit   = '0;
        unit_ok = 1'b0;
        unique case (item.char_byte)
            CH_S: begin
                factor  = FACTOR_S;
                limit   = LIMIT_S;
                unit_ok = 1'b1;
            end
            CH_M: begin
                factor  = FACTOR_M;
                limit   = LIMIT_M;
                unit_ok = 1'b1;
            end
            CH_H: begin
                factor  = FACTOR_H;
                limit   = LIMIT_H;
                unit_ok = 1'b1;
            end
            default: begin
                factor  = '0;
                limit   = '0;
                unit_ok = 1'b0;
            end
        endcase
    end

    // Missing or zero window counts as one
    assign win     = (window_acc_reg == '0) ? 32'd1 : window_acc_reg;
    assign ms_prod = {22'd0, win} * {32'd0, factor};
    assign ok      = (phase_reg == PH_WIN) && unit_ok && (win <= limit);

    always_comb begin
        result.status     = !ok;
        result.rate_count = ok ? rate_acc_reg : '0;
        result.window_ms  = ok ? ms_prod[31:0] : '0;
    end

    // Advance the parse on each byte; clear on the final byte
    always_comb begin
        phase_next      = phase_reg;
        rate_acc_next   = rate_acc_reg;
        window_acc_next = window_acc_reg;
        if (step_en) begin
            if (item.is_last) begin
                phase_next      = PH_RATE;
                rate_acc_next   = '0;
                window_acc_next = '0;
            end else begin
                unique case (phase_reg)
                    PH_RATE: begin
                        if (is_digit) begin
                            if (acc_ovf) begin
                                phase_next = PH_ERR;
                            end else begin
                                rate_acc_next = acc_sum[31:0];
                            end
                        end else if (rate_acc_reg != '0 && item.char_byte == CH_R) begin
                            phase_next = PH_SLASH;
                        end else begin
                            phase_next = PH_ERR;
                        end
                    end
                    PH_SLASH: begin
                        phase_next = (item.char_byte == CH_SLASH) ? PH_WIN : PH_ERR;
                    end
                    PH_WIN: begin
                        if (is_digit && !acc_ovf) begin
                            window_acc_next = acc_sum[31:0];
                        end else begin
                            phase_next = PH_ERR;
                        end
                    end
                    default: begin
                        phase_next = PH_ERR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_RATE;
            rate_acc_reg   <= '0;
            window_acc_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            rate_acc_reg   <= rate_acc_next;
            window_acc_reg <= window_acc_next;
        end
    end

endmodule

@@ sv/rate_spec_parser.sv @@
// Top level of the rate text parser: input stage, parse core, result register.
// Throughput: one byte per cycle with no bubbles between texts, unless a final byte waits for the result register.
// The final byte passes the input register; its result then loads into the result register on m_*.
// Timing is set by the input register, the per-byte step and the result register.
// Reset (aresetn low, synchronous) empties both stages and returns the parse
// to the rate digits phase with both counts at zero.
`timescale 1ns / 1ps
`include "rate_spec_parser_assert.svh"
module rate_spec_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] rate_count, [63:32] window_ms
    output logic        m_tuser    // status
);
    import rsp_pkg::*;

    logic        item_valid;
    rsp_item_t   item;
    rsp_result_t result;
    logic        out_free;
    logic        advance;
    logic        out_load;

    logic        m_valid_reg, m_valid_next;
    rsp_result_t m_data_reg, m_data_next;

    // Step a byte unless it is final and the result register is still full
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = item_valid && (!item.is_last || out_free);
    assign out_load = advance && item.is_last;

    rsp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rsp_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item),
        .result  (result)
    );

    // Hold the result until the downstream takes it
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg.window_ms, m_data_reg.rate_count};
    assign m_tuser  = m_data_reg.status;

    `RSP_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 64'd0)
    `RSP_ASSERT_IMPL(a_ok_rate, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[31:0] != 32'd0)
    `RSP_ASSERT_IMPL(a_ok_win, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[63:32] >= 32'd1000)
    `RSP_ASSERT_NEXT(a_final_out, aclk, aresetn, out_load, m_tvalid)

endmodule

@@ tb/tb_rate_spec_parser.sv @@
// Self-checking testbench of the rate text parser: byte stream in, parsed rate results out.
`timescale 1ns / 1ps
module tb_rate_spec_parser;
    import rsp_pkg::*;

    // One byte of a queued text, with an optional wait for the result side to drain
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain_first;
    } text_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] char_byte
    logic        s_tlast = 1'b0;    // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // [31:0] rate_count, [63:32] window_ms
    logic        m_tuser;           // status

    text_byte_t  text_bytes[$];
    rsp_result_t results_due[$];

    // Parser state mirror
    logic [1:0]  ph = PH_RATE;
    logic [31:0] rate_acc = '0;
    logic [31:0] window_acc = '0;

    int errors = 0;
    int bytes_in = 0;
    int texts_queued = 0;
    int parsed_ok = 0;
    int rejected = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit byte_taken = 1'b0;

    rate_spec_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Advance the parse by one byte; return 1 when the byte closes a text
    function automatic bit parse_char(input logic [7:0] ch, input logic last,
                                      output rsp_result_t res);
        logic [63:0] grown;
        logic [63:0] ms;
        logic [31:0] win;
        logic [21:0] factor;
        bit          digit;
        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        res = '0;
        if (!last) begin
            case (ph)
                PH_RATE: begin
                    if (digit) begin
                        grown = {32'd0, rate_acc} * 64'd10 + (64'(ch) - 64'(CH_ZERO));
                        if (grown > 64'(U32_TOP)) ph = PH_ERR;
                        else rate_acc = grown[31:0];
                    end else if (rate_acc != 0 && ch == CH_R) begin
                        ph = PH_SLASH;
                    end else begin
                        ph = PH_ERR;
                    end
                end
                PH_SLASH: ph = (ch == CH_SLASH) ? PH_WIN : PH_ERR;
                PH_WIN: begin
                    if (digit) begin
                        grown = {32'd0, window_acc} * 64'd10 + (64'(ch) - 64'(CH_ZERO));
                        if (grown > 64'(U32_TOP)) ph = PH_ERR;
                        else window_acc = grown[31:0];
                    end else begin
                        ph = PH_ERR;
                    end
                end
                default: ph = PH_ERR;
            endcase
            return 1'b0;
        end
        // Final byte: resolve the unit, then return to the start
        res.status = 1'b1;
        if (ph == PH_WIN) begin
            factor = '0;
            case (ch)
                CH_S: factor = FACTOR_S;
                CH_M: factor = FACTOR_M;
                CH_H: factor = FACTOR_H;
                default: factor = '0;
            endcase
            if (factor != 0) begin
                win = (window_acc == 0) ? 32'd1 : window_acc;
                ms = 64'(win) * 64'(factor);
                if (ms <= 64'(U32_TOP)) begin
                    res.status = 1'b0;
                    res.rate_count = rate_acc;
                    res.window_ms = ms[31:0];
                end
            end
        end
        ph = PH_RATE;
        rate_acc = '0;
        window_acc = '0;
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, a few long, none in calm stretches
    function automatic int idle_len();
        int r;
        if ((bytes_in / 150) % 4 == 3) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Decimal text of a value with leading zeros
    function automatic string dec_text(input longint unsigned v, input int zeros);
        string s;
        s = $sformatf("%0d", v);
        repeat (zeros) s = {"0", s};
        return s;
    endfunction

    task automatic queue_text(input logic [7:0] chars[$], input bit drain);
        text_byte_t tb_byte;
        for (int i = 0; i < chars.size(); i++) begin
            tb_byte.ch = chars[i];
            tb_byte.last = (i == chars.size() - 1);
            tb_byte.drain_first = drain && (i == 0);
            text_bytes.push_back(tb_byte);
        end
        texts_queued++;
    endtask

    task automatic queue_string(input string s);
        logic [7:0] chars[$];
        for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
        queue_text(chars, 1'b0);
    endtask

    // Sender: offer the next byte, hold it until taken, idle between bytes
    always @(negedge aclk) begin : sender
        text_byte_t nb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            if (send_gap > 0 && hold_left == 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (text_bytes.size() != 0 &&
                         (!text_bytes[0].drain_first || results_due.size() == 0)) begin
                nb = text_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= nb.ch;
                s_tlast <= nb.last;
                send_gap <= idle_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random ready gaps plus one long hold-off partway through
    always @(negedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_in >= 600) begin
            m_tready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (recv_gap > 0) begin
            m_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_tready <= 1'b1;
            recv_gap <= idle_len();
        end
    end

    // Monitor: predict on accepted bytes, check accepted results
    always @(posedge aclk) begin : monitor
        rsp_result_t want;
        rsp_result_t got;
        if (!aresetn) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                bytes_in <= bytes_in + 1;
                if (parse_char(s_tdata, s_tlast, want)) results_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.rate_count = m_tdata[31:0];
                got.window_ms = m_tdata[63:32];
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result status %0d rate %0d window %0d",
                             $time, got.status, got.rate_count, got.window_ms);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (want.status) rejected++;
                    else parsed_ok++;
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.rate_count !== want.rate_count) begin
                        $display("%0t: rate_count expected %0d got %0d",
                                 $time, want.rate_count, got.rate_count);
                        errors++;
                    end
                    if (got.window_ms !== want.window_ms) begin
                        $display("%0t: window_ms expected %0d got %0d",
                                 $time, want.window_ms, got.window_ms);
                        errors++;
                    end
                end
            end
        end
    end

    // Build the stimulus, release reset, wait for the drain, report
    initial begin : stimulus
        logic [7:0]      chars[$];
        logic [7:0]      unit;
        logic [7:0]      tail;
        string           rate_s;
        string           win_s;
        longint unsigned rate_v;
        longint unsigned win_v;
        longint unsigned lim;
        int              pick;
        int              cut;
        bit              drain_set;

        // Directed: unit kinds, missing and zero window, zero rate, early end,
        // bad unit, misplaced unit, byte extremes as one-byte texts
        queue_string("1r/s");
        queue_string("2r/0h");
        queue_string("0r/m");
        queue_string("1r/5x");
        queue_string("3r/m5");
        chars = {8'hFF};
        queue_text(chars, 1'b0);
        chars = {8'h00};
        queue_text(chars, 1'b0);

        // Random: mostly well-formed texts with edge-heavy numbers, rest broken
        drain_set = 1'b0;
        while (text_bytes.size() < 1950) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) rate_v = 64'($urandom_range(1, 999));
            else if (pick < 65) rate_v = 64'($urandom);
            else if (pick < 72) rate_v = 64'hFFFF_FFFF;
            else if (pick < 78) rate_v = 64'h1_0000_0000 + 64'($urandom_range(0, 9));
            else if (pick < 84) rate_v = 64'd0;
            else if (pick < 92) rate_v = 64'($urandom_range(1, 99));
            else rate_v = 64'd4294967290 + 64'($urandom_range(0, 9));
            rate_s = dec_text(rate_v, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);

            case ($urandom_range(0, 2))
                0: begin unit = CH_S; lim = 64'(LIMIT_S); end
                1: begin unit = CH_M; lim = 64'(LIMIT_M); end
                default: begin unit = CH_H; lim = 64'(LIMIT_H); end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 30) win_s = dec_text(64'($urandom_range(1, 99)), 0);
            else if (pick < 40) win_s = "";
            else if (pick < 48) win_s = dec_text(64'd0, $urandom_range(0, 2));
            else if (pick < 58) win_s = dec_text(lim, 0);
            else if (pick < 66) win_s = dec_text(lim + 64'd1, 0);
            else if (pick < 74) win_s = dec_text(lim - 64'd5 + 64'($urandom_range(0, 10)), 0);
            else if (pick < 84) win_s = dec_text(64'($urandom), 0);
            else if (pick < 90)
                win_s = dec_text(64'h1_0000_0000 + 64'($urandom_range(0, 99)), 0);
            else win_s = dec_text(64'hFFFF_FFFF, $urandom_range(0, 1));

            chars.delete();
            for (int i = 0; i < rate_s.len(); i++) chars.push_back(rate_s[i]);
            chars.push_back(CH_R);
            chars.push_back(CH_SLASH);
            for (int i = 0; i < win_s.len(); i++) chars.push_back(win_s[i]);
            chars.push_back(unit);

            // Break about a third of the texts
            if ($urandom_range(0, 99) < 30) begin
                case ($urandom_range(0, 5))
                    0: chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
                    1: begin
                        cut = $urandom_range(1, chars.size());
                        while (chars.size() > cut) void'(chars.pop_back());
                    end
                    2: begin
                        chars.delete();
                        repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
                    end
                    3: chars[chars.size() - 1] = 8'($urandom_range(0, 255));
                    4: begin
                        tail = chars.pop_back();
                        chars.push_back(unit);
                        chars.push_back(8'h37);
                        chars.push_back(tail);
                    end
                    default: chars[rate_s.len() + $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
                endcase
            end

            // Pause the sender once until every pending result has come back
            queue_text(chars, !drain_set && text_bytes.size() >= 1200);
            if (text_bytes.size() >= 1200) drain_set = 1'b1;
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (text_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, results_due.size());
            errors++;
        end

        $display("Sent %0d texts in %0d bytes; %0d parsed, %0d rejected.",
                 texts_queued, bytes_in, parsed_ok, rejected);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Abort a hung run
    initial begin : watchdog
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
